// ----- hdl/wamm_pkg.sv -----
// Package for the windowed average / min / max block.
// Holds the default sizes, the controller-datapath command and status
// structs, and an elaboration-time log2 helper. No dependencies.
`default_nettype none

package wamm_pkg;

  localparam int unsigned WindowDepthDefault = 16;
  localparam int unsigned SampleWidthDefault = 24;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new sample and restart the scan counter
    logic scan;    // issue one window read
    logic commit;  // write the sample back and load the result register
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic scan_last;  // the read being issued is the last window entry
    logic out_free;   // the result register can take a new result
  } sts_t;

  // Floor of log2, only used to size the average shift.
  function automatic int unsigned floor_log2(input int unsigned d);
    int unsigned k;
    int unsigned v;
    k = 0;
    v = d;
    while (v > 1) begin
      v = v >> 1;
      k = k + 1;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/wamm_in_if.sv -----
// Input channel of the windowed average / min / max block.
// Valid/ready handshake carrying one signed sample; no dependencies.
`default_nettype none

interface wamm_in_if #(
  parameter int unsigned SampleWidth = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- hdl/wamm_out_if.sv -----
// Result channel of the windowed average / min / max block.
// Valid/ready handshake carrying five signed values; no dependencies.
`default_nettype none

interface wamm_out_if #(
  parameter int unsigned SampleWidth = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] newest;
  logic signed [SampleWidth-1:0] oldest;
  logic signed [SampleWidth-1:0] window_min;
  logic signed [SampleWidth-1:0] window_max;
  logic signed [SampleWidth-1:0] window_avg;

  modport source (output valid, output newest, output oldest, output window_min,
                  output window_max, output window_avg, input ready);
  modport sink   (input valid, input newest, input oldest, input window_min,
                  input window_max, input window_avg, output ready);
endinterface

`default_nettype wire

// ----- hdl/wamm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the sample window; no dependencies.
`default_nettype none

module wamm_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wamm_ctrl.sv -----
// Controller state machine of the windowed average / min / max block.
// Sequences accept, window scan and commit; depends on wamm_pkg.
`default_nettype none

module wamm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire wamm_pkg::sts_t  sts_i,
  output wamm_pkg::cmd_t       cmd_o
);
  import wamm_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StWait   = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign cmd_o.load   = in_valid_i && (state_q == StIdle);
  assign cmd_o.scan   = (state_q == StScan);
  assign cmd_o.commit = (state_q == StFinish) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StScan;
      end
      StScan: begin
        if (sts_i.scan_last) state_d = StWait;
      end
      // The last read returns during this cycle.
      StWait: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (sts_i.out_free) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish) && !sts_i.out_free |=> (state_q == StFinish))
    else $error("result dropped while the result register was busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) && sts_i.scan_last |=> (state_q == StWait))
    else $error("scan did not stop after the last window entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> (state_q == StScan))
    else $error("accepted transaction did not start a window scan");

endmodule

`default_nettype wire

// ----- hdl/wamm_dp.sv -----
// Datapath of the windowed average / min / max block: window RAM,
// per-entry valid flags, scan min/max, running sum and result register.
// Depends on wamm_pkg and wamm_ram.
`default_nettype none

module wamm_dp #(
  parameter int unsigned WindowDepth = wamm_pkg::WindowDepthDefault,
  parameter int unsigned SampleWidth = wamm_pkg::SampleWidthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire wamm_pkg::cmd_t                cmd_i,
  output wamm_pkg::sts_t                     sts_o,
  input  wire logic signed [SampleWidth-1:0] sample_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic signed      [SampleWidth-1:0] newest_o,
  output logic signed      [SampleWidth-1:0] oldest_o,
  output logic signed      [SampleWidth-1:0] min_o,
  output logic signed      [SampleWidth-1:0] max_o,
  output logic signed      [SampleWidth-1:0] avg_o
);
  import wamm_pkg::*;

  localparam int unsigned AddrWidth = $clog2(WindowDepth);
  localparam int unsigned SumWidth  = SampleWidth + $clog2(WindowDepth);
  localparam int unsigned AvgShift  = floor_log2(WindowDepth);
  localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(WindowDepth - 1);

  logic signed [SampleWidth-1:0] sample_q;
  logic [AddrWidth-1:0]          pos_q;
  logic [AddrWidth-1:0]          nxt_pos;
  logic [AddrWidth-1:0]          cnt_q;
  logic                          rd_vld_q;
  logic                          rd_live_q;
  logic [AddrWidth-1:0]          rd_addr_q;
  logic [WindowDepth-1:0]        vld_q;
  logic [SampleWidth-1:0]        rdata;
  logic signed [SampleWidth-1:0] mem_v;
  logic signed [SampleWidth-1:0] cur_v;
  logic signed [SampleWidth-1:0] old_q;
  logic signed [SampleWidth-1:0] oldest_q;
  logic signed [SampleWidth-1:0] min_q;
  logic signed [SampleWidth-1:0] max_q;
  logic signed [SumWidth-1:0]    sum_q;
  logic signed [SumWidth-1:0]    sum_d;
  logic signed [SumWidth-1:0]    sum_shr;
  logic                          out_vld_q;
  logic signed [SampleWidth-1:0] newest_q;
  logic signed [SampleWidth-1:0] res_oldest_q;
  logic signed [SampleWidth-1:0] res_min_q;
  logic signed [SampleWidth-1:0] res_max_q;
  logic signed [SampleWidth-1:0] res_avg_q;

  wamm_ram #(
    .Width (SampleWidth),
    .Depth (WindowDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (pos_q),
    .wdata_i (sample_q),
    .re_i    (cmd_i.scan),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  assign nxt_pos = (pos_q == LastAddr) ? '0 : pos_q + AddrWidth'(1);

  // Entries never written since reset read as zero.
  assign mem_v = rd_live_q ? $signed(rdata) : '0;
  // The entry at the write position reads as the new sample in place of its stored value.
  assign cur_v = (rd_addr_q == pos_q) ? sample_q : mem_v;

  assign sum_d = sum_q
               - {{(SumWidth-SampleWidth){old_q[SampleWidth-1]}}, old_q}
               + {{(SumWidth-SampleWidth){sample_q[SampleWidth-1]}}, sample_q};
  assign sum_shr = sum_d >>> AvgShift;

  assign sts_o.scan_last = (cnt_q == LastAddr);
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      vld_q     <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.scan) begin
        cnt_q <= cnt_q + AddrWidth'(1);
      end
      if (cmd_i.commit) begin
        vld_q[pos_q] <= 1'b1;
        pos_q        <= nxt_pos;
        sum_q        <= sum_d;
        out_vld_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload state.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
    end
    if (cmd_i.scan) begin
      rd_addr_q <= cnt_q;
      rd_live_q <= vld_q[cnt_q];
    end
    if (rd_vld_q) begin
      if (rd_addr_q == '0) begin
        min_q <= cur_v;
        max_q <= cur_v;
      end else begin
        if (cur_v < min_q) min_q <= cur_v;
        if (cur_v > max_q) max_q <= cur_v;
      end
      if (rd_addr_q == pos_q) old_q <= mem_v;
      if (rd_addr_q == nxt_pos) oldest_q <= cur_v;
    end
    if (cmd_i.commit) begin
      newest_q     <= sample_q;
      res_oldest_q <= oldest_q;
      res_min_q    <= min_q;
      res_max_q    <= max_q;
      res_avg_q    <= sum_shr[SampleWidth-1:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign newest_o    = newest_q;
  assign oldest_o    = res_oldest_q;
  assign min_o       = res_min_q;
  assign max_o       = res_max_q;
  assign avg_o       = res_avg_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !rd_vld_q && !cmd_i.scan)
    else $error("commit overlaps a window read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (pos_q != $past(pos_q)))
    else $error("write position did not advance on commit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (res_min_q <= res_max_q))
    else $error("window minimum exceeds window maximum");

endmodule

`default_nettype wire

// ----- hdl/window_avg_min_max.sv -----
// Each sample is accepted, scanned over the whole window, then committed as a result.
// A sample is taken only once the last is committed; the scan reads one window
// entry per cycle through the single read port of the window RAM.
// A result waiting in the output register stalls only the next commit.
// Reset (rst_ni, asynchronous, active low) clears the write position, running sum
// and per-entry valid flags, so the whole window reads as zero with no clearing pass.
`default_nettype none

module window_avg_min_max #(
  parameter int unsigned WindowDepth = wamm_pkg::WindowDepthDefault,
  parameter int unsigned SampleWidth = wamm_pkg::SampleWidthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wamm_in_if.sink   in_i,
  wamm_out_if.source out_o
);
  import wamm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wamm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wamm_dp #(
    .WindowDepth (WindowDepth),
    .SampleWidth (SampleWidth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (in_i.sample),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .newest_o    (out_o.newest),
    .oldest_o    (out_o.oldest),
    .min_o       (out_o.window_min),
    .max_o       (out_o.window_max),
    .avg_o       (out_o.window_avg)
  );

endmodule

`default_nettype wire
